### rtl/core/clt_pkg.sv
`timescale 1ns / 1ps

package clt_pkg;

  localparam int VAL_W = 32;
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_DUMP   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_ROTATE,
    CELL_DROP
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [VAL_W-1:0]  value;
    logic [IDX_W-1:0]         position;
  } req_item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [VAL_W-1:0]  item_value;
    logic [IDX_W-1:0]         item_index;
    logic                     last;
  } rsp_item_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t                 op;
    logic [CNT_W-1:0]         len;
    logic signed [VAL_W-1:0]  wdata;
    logic signed [VAL_W-1:0]  head;
  } cell_cmd_t;

endpackage

### rtl/core/clt_cell.sv
`timescale 1ns / 1ps

module clt_cell
  import clt_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  cell_cmd_t               cmd,
  input  logic signed [VAL_W-1:0] next_data,
  output logic signed [VAL_W-1:0] data
);

  localparam logic [CNT_W-1:0] POS  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] POS1 = CNT_W'(IDX + 1);

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_LOAD: begin
        if (cmd.len == POS) data <= cmd.wdata;
      end
      CELL_ROTATE: begin
        // tail cell wraps the head around
        if (POS1 < cmd.len) data <= next_data;
        else if (POS1 == cmd.len) data <= cmd.head;
      end
      CELL_DROP: begin
        data <= next_data;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/compacting_list_table.sv
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit values held in a chain of cells,
// one value per cell, cell 0 at the head. A request item is taken while the
// block is idle and worked on in the run state; req_stall is high until that
// work is done. Append writes the cell at the current count, unless the list
// is full, and loads its result item into the output register. Delete, search
// and dump walk the list by rotating the occupied cells through the head, one
// position a cycle while the output register is free; dump emits one result
// item per position of that walk. An empty list or a bad index ends the item
// with a single status result. A full, stalled output register holds the walk.
// Entry contents are undefined until written; only entries below the count
// are ever read.

module compacting_list_table
  import clt_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req_item,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp_item
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE      = CNT_W'(1);

  state_t state, state_next;

  // item being worked on
  mode_t                   op_mode;
  logic signed [VAL_W-1:0] op_value;
  logic [IDX_W-1:0]        op_pos;
  logic [CNT_W-1:0]        n;          // count when the item was taken

  logic [CNT_W-1:0]        len, len_next;    // live count
  logic [CNT_W-1:0]        step, step_next;  // walk position = original index at head
  logic                    found, found_next;
  logic [IDX_W-1:0]        fidx, fidx_next;

  cell_cmd_t               cmd;
  logic                    emit;
  rsp_item_t               res;
  logic                    fire;
  logic                    last_step;
  logic                    hit;

  logic signed [VAL_W-1:0] data [DEPTH];

  // ---------------------------------------------------------------- cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] nxt;
    if (i == DEPTH - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = data[i+1];
    end
    clt_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .next_data (nxt),
      .data      (data[i])
    );
  end

  assign req_stall = (state != S_IDLE);

  // ------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
      step  <= '0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      step  <= step_next;
      found <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    fidx <= fidx_next;
    if (state == S_IDLE && req_valid) begin
      op_mode  <= req_item.mode;
      op_value <= req_item.value;
      op_pos   <= req_item.position;
      n        <= len;
    end
  end

  always_comb begin
    state_next = state;
    len_next   = len;
    step_next  = step;
    found_next = found;
    fidx_next  = fidx;
    cmd.op     = CELL_HOLD;
    cmd.len    = len;
    cmd.wdata  = op_value;
    cmd.head   = data[0];
    emit       = 1'b0;
    res        = '{status: ST_OK, item_value: '0, item_index: '0, last: 1'b1};
    // output register free this cycle
    fire       = !rsp_valid || !rsp_stall;
    last_step  = (step + ONE == n);
    hit        = 1'b0;

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_RUN;
          step_next  = '0;
          found_next = 1'b0;
        end
      end
      S_RUN: begin
        if (fire) begin
          case (op_mode)
            MODE_APPEND: begin
              emit       = 1'b1;
              state_next = S_IDLE;
              res.item_value = op_value;
              if (len == FULL_CNT) begin
                res.status = ST_FULL;
              end else begin
                cmd.op         = CELL_LOAD;
                len_next       = len + ONE;
                res.item_index = IDX_W'(len);
              end
            end
            MODE_DELETE: begin
              if (n == '0) begin
                emit       = 1'b1;
                res.status = ST_EMPTY;
                state_next = S_IDLE;
              end else if (CNT_W'(op_pos) >= n) begin
                emit           = 1'b1;
                res.status     = ST_BAD_INDEX;
                res.item_index = op_pos;
                state_next     = S_IDLE;
              end else begin
                if (step == CNT_W'(op_pos)) begin
                  // head is the victim: pull the rest down, no wrap
                  cmd.op         = CELL_DROP;
                  len_next       = len - ONE;
                  emit           = 1'b1;
                  res.item_value = data[0];
                  res.item_index = op_pos;
                end else begin
                  cmd.op = CELL_ROTATE;
                end
                if (last_step) state_next = S_IDLE;
                else step_next = step + ONE;
              end
            end
            MODE_SEARCH: begin
              if (n == '0) begin
                emit       = 1'b1;
                res.status = ST_EMPTY;
                state_next = S_IDLE;
              end else begin
                cmd.op = CELL_ROTATE;
                hit    = !found && (data[0] == op_value);
                if (hit) begin
                  found_next = 1'b1;
                  fidx_next  = IDX_W'(step);
                end
                if (last_step) begin
                  emit           = 1'b1;
                  state_next     = S_IDLE;
                  res.item_value = op_value;
                  if (found) res.item_index = fidx;
                  else if (hit) res.item_index = IDX_W'(step);
                  else res.status = ST_NOT_FOUND;
                end else begin
                  step_next = step + ONE;
                end
              end
            end
            default: begin
              if (n == '0) begin
                emit       = 1'b1;
                res.status = ST_EMPTY;
                state_next = S_IDLE;
              end else begin
                cmd.op         = CELL_ROTATE;
                emit           = 1'b1;
                res.item_value = data[0];
                res.item_index = IDX_W'(step);
                res.last       = last_step;
                if (last_step) state_next = S_IDLE;
                else step_next = step + ONE;
              end
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) rsp_item <= res;
  end

  // ------------------------------------------------------------- checks
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= FULL_CNT)
    else $error("count above depth");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!rsp_valid || !rsp_stall))
    else $error("result loaded over a stalled one");

  a_drop_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && cmd.op == CELL_DROP) |=> (len == $past(len) - ONE))
    else $error("delete did not shrink the list");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && n != '0) |-> (step < n))
    else $error("walk ran past the list");

endmodule

### sim/tb_compacting_list_table.sv
`timescale 1ns / 1ps

module tb_compacting_list_table;
  import clt_pkg::*;

  localparam int LIST_DEPTH     = 64;
  localparam int RANDOM_ITEMS   = 146;
  localparam int TAIL_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [VAL_W-1:0] V_MIN  = 32'h8000_0000;
  localparam logic [VAL_W-1:0] V_MAX  = 32'h7fff_ffff;
  localparam logic [VAL_W-1:0] V_NEG1 = 32'hffff_ffff;

  // one row of the directed table; fill asks for the list to be topped up
  // with random appends before the row's item goes out
  typedef struct {
    bit        fill;
    req_item_t item;
    bit        typed;
    rsp_item_t want;
  } dir_row_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req_item = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp_item;

  // shadow copy of the list, advanced once per accepted item
  logic [VAL_W-1:0] shadow_vals [LIST_DEPTH];
  int               shadow_len = 0;

  rsp_item_t pending_rsp [$];
  rsp_item_t want_rsp;
  int        bad_items = 0;
  int        quiet_cycles = 0;

  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  logic [7:0]  rx_phase = '0;
  int unsigned stall_left = 0;

  dir_row_t dir_rows [23];

  compacting_list_table #(
    .DEPTH (LIST_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // list behavior: appends results for one item to pending_rsp and
  // updates the shadow list
  function automatic void apply_list_op(input req_item_t it);
    rsp_item_t r;
    int        i;
    int        hit;
    r      = '0;
    r.last = 1'b1;
    case (it.mode)
      MODE_APPEND: begin
        r.item_value = it.value;
        if (shadow_len >= LIST_DEPTH) begin
          r.status = ST_FULL;  // rejected, list untouched
        end else begin
          shadow_vals[shadow_len] = it.value;
          r.status     = ST_OK;
          r.item_index = 6'(shadow_len);
          shadow_len++;
        end
        pending_rsp.push_back(r);
      end
      MODE_DELETE: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(it.position) >= shadow_len) begin
          r.status     = ST_BAD_INDEX;
          r.item_index = it.position;
        end else begin
          r.status     = ST_OK;
          r.item_value = shadow_vals[it.position];
          r.item_index = it.position;
          // close the gap
          for (i = int'(it.position); i + 1 < shadow_len; i++)
            shadow_vals[i] = shadow_vals[i+1];
          shadow_len--;
        end
        pending_rsp.push_back(r);
      end
      MODE_SEARCH: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          hit = -1;
          for (i = 0; i < shadow_len && hit < 0; i++)
            if (shadow_vals[i] == it.value) hit = i;
          r.item_value = it.value;
          if (hit >= 0) begin
            r.status     = ST_OK;
            r.item_index = 6'(hit);
          end else begin
            r.status = ST_NOT_FOUND;
          end
        end
        pending_rsp.push_back(r);
      end
      MODE_DUMP: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
          pending_rsp.push_back(r);
        end else begin
          for (i = 0; i < shadow_len; i++) begin
            r.status     = ST_OK;
            r.item_value = shadow_vals[i];
            r.item_index = 6'(i);
            r.last       = (i == shadow_len - 1);
            pending_rsp.push_back(r);
          end
        end
      end
    endcase
  endfunction

  function automatic dir_row_t cue(input bit fill, input mode_t m,
                                   input logic [VAL_W-1:0] v,
                                   input logic [IDX_W-1:0] p, input bit typed,
                                   input status_t s, input logic [VAL_W-1:0] ev,
                                   input logic [IDX_W-1:0] ei);
    dir_row_t d;
    d.fill            = fill;
    d.item.mode       = m;
    d.item.value      = v;
    d.item.position   = p;
    d.typed           = typed;
    d.want.status     = s;
    d.want.item_value = ev;
    d.want.item_index = ei;
    d.want.last       = 1'b1;
    return d;
  endfunction

  // random item; grow phases lean toward appends, shrink phases toward deletes
  function automatic req_item_t roll_item(input bit grow);
    req_item_t   it;
    int unsigned r;
    int unsigned vr;
    vr = $urandom_range(0, 99);
    if (vr < 50)      it.value = $urandom();
    else if (vr < 80) it.value = $urandom_range(0, 15) - 8;  // small, repeats often
    else if (vr < 87) it.value = V_MIN;
    else if (vr < 94) it.value = V_MAX;
    else              it.value = V_NEG1;
    it.position = IDX_W'($urandom_range(0, 63));
    r = $urandom_range(0, 99);
    if (r < (grow ? 70 : 15)) begin
      it.mode = MODE_APPEND;
    end else if (r < (grow ? 80 : 75)) begin
      it.mode = MODE_DELETE;
      if (shadow_len > 0 && $urandom_range(0, 4) != 0)
        it.position = IDX_W'($urandom_range(0, shadow_len - 1));
    end else if (r < 92) begin
      it.mode = MODE_SEARCH;
      if (shadow_len > 0 && $urandom_range(0, 4) < 3)
        it.value = shadow_vals[$urandom_range(0, shadow_len - 1)];
    end else begin
      it.mode = MODE_DUMP;
    end
    return it;
  endfunction

  // present one item, hold it until taken, then maybe idle a while
  task automatic push_item(input req_item_t it, input bit typed, input rsp_item_t want);
    int unsigned gap;
    req_valid <= 1'b1;
    req_item  <= it;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    apply_list_op(it);
    if (typed) begin
      // swap in the hand-written answer for single-result rows
      void'(pending_rsp.pop_back());
      pending_rsp.push_back(want);
    end
    gap = pick_gap(tx_calm);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender holds off until every outstanding result is back
  task automatic drain_all();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic void flag_bad(input string why, input rsp_item_t w,
                                   input rsp_item_t g);
    bad_items++;
    if (bad_items <= 10)
      $display("%0t mismatch (%s): want st=%0d val=%0d idx=%0d last=%0d,",
               $realtime, why, w.status, w.item_value, w.item_index, w.last,
               " got st=%0d val=%0d idx=%0d last=%0d",
               g.status, g.item_value, g.item_index, g.last);
  endfunction

  // result stall: random runs, calm stretches picked at random each time rx_phase wraps
  always @(posedge clk) begin : rx_stall_gen
    int unsigned n;
    rx_phase <= rx_phase + 8'd1;
    if (rx_phase == 8'd0) rx_calm <= ($urandom_range(0, 3) == 0);
    if (stall_left != 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      n = pick_gap(rx_calm);
      rsp_stall  <= (n != 0);
      stall_left <= (n == 0) ? 0 : n - 1;
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp.size() == 0) begin
          flag_bad("unexpected item", '0, rsp_item);
        end else begin
          want_rsp = pending_rsp.pop_front();
          if (rsp_item.status !== want_rsp.status ||
              rsp_item.item_value !== want_rsp.item_value ||
              rsp_item.item_index !== want_rsp.item_index ||
              rsp_item.last !== want_rsp.last)
            flag_bad("field", want_rsp, rsp_item);
        end
      end
      if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int        k;
    int        phase_left;
    bit        grow;
    req_item_t fill_item;

    // empty list cases, extremes, duplicates, bad index, full list
    dir_rows = '{
      cue(0, MODE_DUMP,   '0,     '0,    1, ST_EMPTY,     '0,     '0),
      cue(0, MODE_DELETE, '0,     '0,    1, ST_EMPTY,     '0,     '0),
      cue(0, MODE_SEARCH, 32'd5,  '0,    1, ST_EMPTY,     '0,     '0),
      cue(0, MODE_APPEND, V_MIN,  6'h3f, 1, ST_OK,        V_MIN,  6'd0),
      cue(0, MODE_APPEND, V_MAX,  '0,    1, ST_OK,        V_MAX,  6'd1),
      cue(0, MODE_APPEND, '0,     '0,    1, ST_OK,        '0,     6'd2),
      cue(0, MODE_APPEND, V_NEG1, '0,    1, ST_OK,        V_NEG1, 6'd3),
      cue(0, MODE_APPEND, V_MAX,  '0,    1, ST_OK,        V_MAX,  6'd4),
      cue(0, MODE_SEARCH, V_MAX,  '0,    1, ST_OK,        V_MAX,  6'd1),
      cue(0, MODE_SEARCH, 32'd12345, '0, 1, ST_NOT_FOUND, 32'd12345, 6'd0),
      cue(0, MODE_DELETE, '0,     6'd63, 1, ST_BAD_INDEX, '0,     6'd63),
      cue(0, MODE_DELETE, '0,     6'd5,  1, ST_BAD_INDEX, '0,     6'd5),
      cue(0, MODE_DUMP,   '0,     '0,    0, ST_OK,        '0,     '0),
      cue(0, MODE_DELETE, '0,     6'd0,  1, ST_OK,        V_MIN,  6'd0),
      cue(0, MODE_DELETE, '0,     6'd3,  1, ST_OK,        V_MAX,  6'd3),
      cue(0, MODE_SEARCH, V_NEG1, '0,    1, ST_OK,        V_NEG1, 6'd2),
      cue(0, MODE_DUMP,   '0,     '0,    0, ST_OK,        '0,     '0),
      cue(1, MODE_APPEND, 32'd77, '0,    1, ST_FULL,      32'd77, 6'd0),
      cue(0, MODE_DUMP,   '0,     '0,    0, ST_OK,        '0,     '0),
      cue(0, MODE_SEARCH, V_MIN,  '0,    0, ST_OK,        '0,     '0),
      cue(0, MODE_DELETE, '0,     6'd63, 0, ST_OK,        '0,     '0),
      cue(0, MODE_APPEND, V_MIN,  '0,    0, ST_OK,        '0,     '0),
      cue(0, MODE_DELETE, '0,     6'd0,  0, ST_OK,        '0,     '0)
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].fill) begin
        while (shadow_len < LIST_DEPTH) begin
          fill_item.mode     = MODE_APPEND;
          fill_item.value    = $urandom();
          fill_item.position = IDX_W'($urandom_range(0, 63));
          push_item(fill_item, 1'b0, '0);
        end
      end
      push_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
    end

    drain_all();

    // random part in phases of varying bias and idling
    phase_left = 0;
    grow = ($urandom_range(0, 1) != 0);
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(15, 50);
        grow       = !grow;
        tx_calm    = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) == 0) drain_all();
      end
      phase_left--;
      push_item(roll_item(grow), 1'b0, '0);
    end

    drain_all();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_items == 0 && pending_rsp.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/core/clt_pkg.sv
rtl/core/clt_cell.sv
rtl/core/compacting_list_table.sv
sim/tb_compacting_list_table.sv
